[design/strong_connectivity_check_top_assert.svh]
// Assertion macros shared by the strong connectivity check modules.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef STRONG_CONNECTIVITY_CHECK_TOP_ASSERT_SVH
`define STRONG_CONNECTIVITY_CHECK_TOP_ASSERT_SVH

`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`define SCC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/scc_pkg.sv]
package scc_pkg;

  localparam int unsigned SCC_QDEPTH = 2;
  localparam int unsigned SCC_QPW    = $clog2(SCC_QDEPTH);
  localparam int unsigned SCC_QCW    = $clog2(SCC_QDEPTH + 1);

  typedef struct packed {
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic        wr_en;
    logic        check;
  } scc_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_SEL,
    BK_ACC,
    BK_DONE
  } scc_bk_state_e;

  function automatic logic [4:0] lsb_index(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

[design/scc_front.sv]
module scc_front #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic              push,
  input  logic [4:0]        row_index_i,
  input  logic [31:0]       row_bits_i,
  input  logic              last_row_i,
  input  logic              q_full_i,
  output logic              full,
  output logic              cmd_push_o,
  output scc_pkg::scc_cmd_t cmd_o
);
  import scc_pkg::*;

  // Rows beyond the store are dropped, but a last row still starts the check.
  assign full             = q_full_i;
  assign cmd_push_o       = push && !q_full_i;
  assign cmd_o.row_index  = row_index_i;
  assign cmd_o.row_bits   = row_bits_i;
  assign cmd_o.wr_en      = (7'(row_index_i) < 7'(MAX_VERTICES));
  assign cmd_o.check      = last_row_i;

endmodule

[design/scc_queue.sv]
`include "strong_connectivity_check_top_assert.svh"

module scc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  scc_pkg::scc_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output scc_pkg::scc_cmd_t data_o
);
  import scc_pkg::*;

  scc_cmd_t             slot_q [SCC_QDEPTH];
  logic [SCC_QPW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [SCC_QPW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [SCC_QCW-1:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == SCC_QCW'(SCC_QDEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + SCC_QPW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + SCC_QPW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + SCC_QCW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - SCC_QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  `SCC_ASSERT(a_count_bound, count_q <= SCC_QCW'(SCC_QDEPTH), "Queue count above depth.")
  `SCC_ASSERT_IMPLIES(a_no_push_full, full_o, !push_i, "Request pushed into a full queue.")
  `SCC_ASSERT_IMPLIES(a_no_pop_empty, !valid_o, !pop_i, "Request popped from an empty queue.")

endmodule

[design/scc_back.sv]
`include "strong_connectivity_check_top_assert.svh"

module scc_back #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        vertex_count_i,
  input  logic              cmd_valid_i,
  input  scc_pkg::scc_cmd_t cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop,
  output logic              empty,
  output logic              strongly_connected_o
);
  import scc_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned LIM = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;

  scc_bk_state_e state_q, state_d;
  logic [31:0]   visited_q, visited_d;
  logic [31:0]   frontier_q, frontier_d;
  logic [4:0]    start_q, start_d;
  logic          verdict_q, verdict_d;
  logic          res_valid_q, res_valid_d;
  logic          res_data_q, res_data_d;

  logic [31:0]   mem [MAX_VERTICES];
  logic [31:0]   rdata_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic [5:0]    n_used;
  logic [31:0]   mask;
  logic          last_start;
  logic [31:0]   fresh;

  assign n_used     = (vertex_count_i > 6'(LIM)) ? 6'(LIM) : vertex_count_i;
  assign mask       = (32'd1 << n_used) - 32'd1;
  assign last_start = ((6'(start_q) + 6'd1) == n_used);
  assign fresh      = rdata_q & mask & ~visited_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && cmd_i.check) begin
          state_d = (n_used == 6'd0) ? BK_DONE : BK_START;
        end
      end
      BK_START: state_d = BK_SEL;
      BK_SEL: begin
        if (frontier_q != '0) begin
          state_d = BK_ACC;
        end else if ((visited_q == mask) && !last_start) begin
          state_d = BK_START;
        end else begin
          state_d = BK_DONE;
        end
      end
      BK_ACC: state_d = BK_SEL;
      BK_DONE: begin
        if (!res_valid_q) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    rd_addr     = AW'(lsb_index(frontier_q));
    visited_d   = visited_q;
    frontier_d  = frontier_q;
    start_d     = start_q;
    verdict_d   = verdict_q;
    res_valid_d = res_valid_q;
    res_data_d  = res_data_q;
    if (pop && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          mem_we    = cmd_i.wr_en;
          start_d   = '0;
          verdict_d = 1'b1;
        end
      end
      BK_START: begin
        visited_d  = 32'd1 << start_q;
        frontier_d = 32'd1 << start_q;
      end
      BK_SEL: begin
        if (frontier_q != '0) begin
          frontier_d = frontier_q & (frontier_q - 32'd1);
        end else if (visited_q != mask) begin
          verdict_d = 1'b0;
        end else if (!last_start) begin
          start_d = start_q + 5'd1;
        end
      end
      BK_ACC: begin
        visited_d  = visited_q | fresh;
        frontier_d = frontier_q | fresh;
      end
      BK_DONE: begin
        if (!res_valid_q) begin
          res_valid_d = 1'b1;
          res_data_d  = verdict_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      visited_q   <= '0;
      frontier_q  <= '0;
      start_q     <= '0;
      verdict_q   <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      visited_q   <= visited_d;
      frontier_q  <= frontier_d;
      start_q     <= start_d;
      verdict_q   <= verdict_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_data_q <= res_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(cmd_i.row_index)] <= cmd_i.row_bits;
    end
    rdata_q <= mem[rd_addr];
  end

  assign empty                = !res_valid_q;
  assign strongly_connected_o = res_data_q;

  `SCC_ASSERT_IMPLIES(a_pop_idle_only, cmd_pop_o, state_q == BK_IDLE,
                      "Request taken from the queue during a walk.")
  `SCC_ASSERT_IMPLIES(a_visited_in_mask, state_q == BK_SEL, (visited_q & ~mask) == '0,
                      "Visited set holds a vertex beyond the count.")
  `SCC_ASSERT_IMPLIES(a_frontier_visited, state_q == BK_SEL, (frontier_q & ~visited_q) == '0,
                      "Frontier holds an unvisited vertex.")
  `SCC_ASSERT_IMPLIES(a_done_delivers, (state_q == BK_DONE) && !res_valid_q,
                      ##1 res_valid_q, "Finished walk did not fill the result slot.")

endmodule

[design/strong_connectivity_check_top.sv]
// Strong connectivity check of a directed graph of up to 32 vertices.
// Input channel: one adjacency row per request (row_index_i, row_bits_i,
// last_row_i), taken when push is high and full is low. Rows load at one
// per cycle, unless full, into a two-entry request queue, then row memory.
// A request with last_row_i set stores its row and starts the check.
// Result channel: strongly_connected_o is valid while empty is low and is
// taken when pop is high. Only a last row produces a result.
// Configuration: cfg_vertex_count_i is written when cfg_valid_i and
// cfg_ready_o are both high; cfg_ready_o is always high.
// The check walks one start vertex at a time; each start selects and
// accumulates its reached vertices one at a time, as the single row memory
// read port returns one row per reached vertex.
// Reset empties the queue and the result slot and sets the vertex count to
// 32; rows are undefined until written. While a result waits to be taken,
// rows keep loading until the queue fills, and the next check holds its
// answer until the slot is free.
module strong_connectivity_check_top #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  row_index_i,
  input  logic [31:0] row_bits_i,
  input  logic        last_row_i,
  output logic        empty,
  input  logic        pop,
  output logic        strongly_connected_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_vertex_count_i
);
  import scc_pkg::*;

  logic [5:0] vertex_count_q, vertex_count_d;
  logic       q_full;
  logic       cmd_push;
  scc_cmd_t   cmd_in;
  logic       cmd_valid;
  logic       cmd_pop;
  scc_cmd_t   cmd_out;

  assign cfg_ready_o    = 1'b1;
  assign vertex_count_d = (cfg_valid_i && cfg_ready_o) ? cfg_vertex_count_i : vertex_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= 6'd32;
    end else begin
      vertex_count_q <= vertex_count_d;
    end
  end

  scc_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .push        (push),
    .row_index_i (row_index_i),
    .row_bits_i  (row_bits_i),
    .last_row_i  (last_row_i),
    .q_full_i    (q_full),
    .full        (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  scc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  scc_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .vertex_count_i       (vertex_count_q),
    .cmd_valid_i          (cmd_valid),
    .cmd_i                (cmd_out),
    .cmd_pop_o            (cmd_pop),
    .pop                  (pop),
    .empty                (empty),
    .strongly_connected_o (strongly_connected_o)
  );

endmodule
